// ----- rtl/core/utf8d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 sequence decoder pipeline.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned CP_W    = 31;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned PAY_W   = 6;
    localparam int unsigned N_CONT  = 5;

    localparam logic [CP_W-1:0] REPL_CHAR  = 31'h0000_FFFD;
    localparam logic [CP_W-1:0] SURR_LO    = 31'h0000_D800;
    localparam logic [CP_W-1:0] SURR_HI    = 31'h0000_DFFF;
    localparam logic [CP_W-1:0] NONCHAR_FE = 31'h0000_FFFE;
    localparam logic [CP_W-1:0] NONCHAR_FF = 31'h0000_FFFF;

    // Stage 1 -> stage 2: sequence length, masked lead bits, continuation payloads
    typedef struct packed {
        logic [LEN_W-1:0]             len;
        logic [6:0]                   lead_bits;
        logic [N_CONT-1:0][PAY_W-1:0] cont;
        logic                         err;
    } t_s1;

    // Stage 2 -> stage 3: assembled value awaiting range checks
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [CP_W-1:0]  value;
        logic             err;
    } t_s2;

    // Smallest value allowed for each form (anything below is overlong)
    function automatic logic [CP_W-1:0] floor_for_len(input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] f;
        unique case (len)
            3'd2:    f = 31'h0000_0080;
            3'd3:    f = 31'h0000_0800;
            3'd4:    f = 31'h0001_0000;
            3'd5:    f = 31'h0020_0000;
            3'd6:    f = 31'h0400_0000;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/core/utf8_sequence_decoder.sv -----
`timescale 1ns / 1ps
// Requests pass the classify, assemble and check registers in turn to o_valid.
// Throughput: one request per cycle while i_ready is high; each stage holds one
//   request and refills in the cycle it drains, so a full stream never bubbles.
// Stalls back up stage by stage through the ready chain; nothing is dropped.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// utf8_sequence_decoder
// Decodes one 1..6 byte UTF-8 sequence (RFC 2279 forms) into a code point,
// returning U+FFFD for any malformed, short, overlong or disallowed input.
// ----------------------------------------------------------------------------
module utf8_sequence_decoder
    import utf8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_lead_byte,
    input  logic [BYTE_W-1:0] i_cont_byte_1,
    input  logic [BYTE_W-1:0] i_cont_byte_2,
    input  logic [BYTE_W-1:0] i_cont_byte_3,
    input  logic [BYTE_W-1:0] i_cont_byte_4,
    input  logic [BYTE_W-1:0] i_cont_byte_5,
    input  logic [LEN_W-1:0]  i_avail_len,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CP_W-1:0]   o_code_point
);

    // stage 1 -> 2
    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;

    // stage 2 -> 3
    logic s2_valid;
    logic s2_ready;
    t_s2  s2_data;

    // Stage 1: lead byte class, length vs. available bytes, 10xxxxxx tags.
    // Any of these failing sets err, which rides along to force U+FFFD.
    utf8d_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_lead_byte   (i_lead_byte),
        .i_cont_byte_1 (i_cont_byte_1),
        .i_cont_byte_2 (i_cont_byte_2),
        .i_cont_byte_3 (i_cont_byte_3),
        .i_cont_byte_4 (i_cont_byte_4),
        .i_cont_byte_5 (i_cont_byte_5),
        .i_avail_len   (i_avail_len),
        .o_valid       (s1_valid),
        .i_ready       (s1_ready),
        .o_s1          (s1_data)
    );

    // Stage 2: concatenate payload bits per sequence length.
    utf8d_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2_data)
    );

    // Stage 3: range checks, then the output register itself.
    utf8d_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s2_valid),
        .o_ready      (s2_ready),
        .i_s2         (s2_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_point (o_code_point)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Surrogates never leave the block.
    a_no_surrogate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !((o_code_point >= SURR_LO) && (o_code_point <= SURR_HI)))
        else $error("surrogate code point on output");

    // U+FFFE and U+FFFF never leave the block.
    a_no_nonchar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_code_point != NONCHAR_FE) && (o_code_point != NONCHAR_FF)))
        else $error("noncharacter on output");

    // An empty output stage frees the whole ready chain.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage empty");

endmodule

// ----- rtl/core/utf8d_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_classify
// Stage 1: decodes the lead byte, checks buffer length and continuation tags.
// ----------------------------------------------------------------------------
module utf8d_classify
    import utf8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_lead_byte,
    input  logic [BYTE_W-1:0] i_cont_byte_1,
    input  logic [BYTE_W-1:0] i_cont_byte_2,
    input  logic [BYTE_W-1:0] i_cont_byte_3,
    input  logic [BYTE_W-1:0] i_cont_byte_4,
    input  logic [BYTE_W-1:0] i_cont_byte_5,
    input  logic [LEN_W-1:0]  i_avail_len,
    output logic              o_valid,
    input  logic              i_ready,
    output t_s1               o_s1
);

    logic                       r_vld;
    t_s1                        r_s1;
    t_s1                        n_s1;
    logic [LEN_W-1:0]           len;
    logic [6:0]                 lead_bits;
    logic                       bad_lead;
    logic [N_CONT-1:0][BYTE_W-1:0] cb;
    logic [N_CONT-1:0]          bad_cont;

    assign cb = {i_cont_byte_5, i_cont_byte_4, i_cont_byte_3, i_cont_byte_2, i_cont_byte_1};

    always_comb begin
        bad_lead  = 1'b0;
        len       = 3'd1;
        lead_bits = '0;
        unique casez (i_lead_byte)
            8'b0???_????: begin
                len = 3'd1; lead_bits = i_lead_byte[6:0];
            end
            8'b110?_????: begin
                len = 3'd2; lead_bits = {2'b00, i_lead_byte[4:0]};
            end
            8'b1110_????: begin
                len = 3'd3; lead_bits = {3'b000, i_lead_byte[3:0]};
            end
            8'b1111_0???: begin
                len = 3'd4; lead_bits = {4'b0000, i_lead_byte[2:0]};
            end
            8'b1111_10??: begin
                len = 3'd5; lead_bits = {5'b00000, i_lead_byte[1:0]};
            end
            8'b1111_110?: begin
                len = 3'd6; lead_bits = {6'b000000, i_lead_byte[0]};
            end
            default: begin
                bad_lead = 1'b1;
            end
        endcase
    end

    // a continuation byte only counts when the form reaches it
    always_comb begin
        for (int k = 0; k < N_CONT; k++) begin
            bad_cont[k] = (cb[k][7:6] != 2'b10) && (len > LEN_W'(k + 1));
        end
    end

    always_comb begin
        n_s1.len       = len;
        n_s1.lead_bits = lead_bits;
        for (int k = 0; k < N_CONT; k++) begin
            n_s1.cont[k] = cb[k][PAY_W-1:0];
        end
        n_s1.err = bad_lead || (i_avail_len < len) || (|bad_cont);
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_vld;
    assign o_s1    = r_s1;

endmodule

// ----- rtl/core/utf8d_assemble.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_assemble
// Stage 2: packs lead bits and continuation payloads into the code point.
// ----------------------------------------------------------------------------
module utf8d_assemble
    import utf8d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_s1,
    output logic o_valid,
    input  logic i_ready,
    output t_s2  o_s2
);

    logic            r_vld;
    t_s2             r_s2;
    t_s2             n_s2;
    logic [CP_W-1:0] value;

    // lead bits sit above (len - 1) six-bit groups
    always_comb begin
        unique case (i_s1.len)
            3'd2:    value = CP_W'({i_s1.lead_bits, i_s1.cont[0]});
            3'd3:    value = CP_W'({i_s1.lead_bits, i_s1.cont[0], i_s1.cont[1]});
            3'd4:    value = CP_W'({i_s1.lead_bits, i_s1.cont[0], i_s1.cont[1],
                                    i_s1.cont[2]});
            3'd5:    value = CP_W'({i_s1.lead_bits[1:0], i_s1.cont[0], i_s1.cont[1],
                                    i_s1.cont[2], i_s1.cont[3]});
            3'd6:    value = {i_s1.lead_bits[0], i_s1.cont[0], i_s1.cont[1],
                              i_s1.cont[2], i_s1.cont[3], i_s1.cont[4]};
            default: value = CP_W'(i_s1.lead_bits);
        endcase
    end

    always_comb begin
        n_s2.len   = i_s1.len;
        n_s2.value = value;
        n_s2.err   = i_s1.err;
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_vld;
    assign o_s2    = r_s2;

endmodule

// ----- rtl/core/utf8d_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_check
// Stage 3: overlong, surrogate and noncharacter checks; output register.
// ----------------------------------------------------------------------------
module utf8d_check
    import utf8d_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_s2             i_s2,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CP_W-1:0] o_code_point
);

    logic            r_vld;
    logic [CP_W-1:0] r_cp;
    logic [CP_W-1:0] n_cp;
    logic            reject;

    always_comb begin
        reject = i_s2.err
              || (i_s2.value < floor_for_len(i_s2.len))
              || ((i_s2.value >= SURR_LO) && (i_s2.value <= SURR_HI))
              || (i_s2.value == NONCHAR_FE)
              || (i_s2.value == NONCHAR_FF);
        n_cp = reject ? REPL_CHAR : i_s2.value;
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cp <= n_cp;
        end
    end

    assign o_valid      = r_vld;
    assign o_code_point = r_cp;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives UTF-8 byte sequences of every form (1 to 6 bytes) into the decoder
// under random sender gaps and receiver stalls. Each code point is checked
// against an in-bench decoder, in order.
// ----------------------------------------------------------------------------
module testbench;
    import utf8d_pkg::*;

    // One request as seen on the input ports; bytes[0] is the lead byte
    typedef struct packed {
        logic [LEN_W-1:0]             avail;
        logic [5:0][BYTE_W-1:0]       bytes;
    } t_utf8_request;

    // Decoded value still owed by the block, kept with its request for reports
    typedef struct packed {
        t_utf8_request   req;
        logic [CP_W-1:0] cp;
    } t_owed_code_point;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [BYTE_W-1:0] i_lead_byte   = '0;
    logic [BYTE_W-1:0] i_cont_byte_1 = '0;
    logic [BYTE_W-1:0] i_cont_byte_2 = '0;
    logic [BYTE_W-1:0] i_cont_byte_3 = '0;
    logic [BYTE_W-1:0] i_cont_byte_4 = '0;
    logic [BYTE_W-1:0] i_cont_byte_5 = '0;
    logic [LEN_W-1:0]  i_avail_len   = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [CP_W-1:0]   o_code_point;

    t_owed_code_point owed_code_points[$];

    int unsigned send_idle_pct      = 0;
    int unsigned recv_idle_pct      = 0;
    int unsigned hold_off_request   = 0;
    int unsigned sequences_sent     = 0;
    int unsigned code_points_seen   = 0;
    int unsigned replacements_seen  = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned mismatch_count     = 0;

    utf8_sequence_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_lead_byte   (i_lead_byte),
        .i_cont_byte_1 (i_cont_byte_1),
        .i_cont_byte_2 (i_cont_byte_2),
        .i_cont_byte_3 (i_cont_byte_3),
        .i_cont_byte_4 (i_cont_byte_4),
        .i_cont_byte_5 (i_cont_byte_5),
        .i_avail_len   (i_avail_len),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_point  (o_code_point)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Form limits: smallest and largest value each length may carry
    // ------------------------------------------------------------------
    function automatic logic [CP_W-1:0] form_floor(input int unsigned nbytes);
        case (nbytes)
            2:       return 31'h0000_0080;
            3:       return 31'h0000_0800;
            4:       return 31'h0001_0000;
            5:       return 31'h0020_0000;
            6:       return 31'h0400_0000;
            default: return 31'h0000_0000;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] form_ceiling(input int unsigned nbytes);
        case (nbytes)
            2:       return 31'h0000_07FF;
            3:       return 31'h0000_FFFF;
            4:       return 31'h001F_FFFF;
            5:       return 31'h03FF_FFFF;
            6:       return 31'h7FFF_FFFF;
            default: return 31'h0000_007F;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Predictor: decode one request the way the block must
    // ------------------------------------------------------------------
    function automatic logic [CP_W-1:0] decode_utf8(input t_utf8_request req);
        logic [BYTE_W-1:0] lead;
        logic [CP_W-1:0]   acc;
        int unsigned       nbytes;
        int unsigned       k;
        lead = req.bytes[0];
        casez (lead)
            8'b0???????: begin acc = 31'(lead[6:0]); nbytes = 1; end
            8'b110?????: begin acc = 31'(lead[4:0]); nbytes = 2; end
            8'b1110????: begin acc = 31'(lead[3:0]); nbytes = 3; end
            8'b11110???: begin acc = 31'(lead[2:0]); nbytes = 4; end
            8'b111110??: begin acc = 31'(lead[1:0]); nbytes = 5; end
            8'b1111110?: begin acc = 31'(lead[0]);   nbytes = 6; end
            default:     return REPL_CHAR;  // stray continuation, 0xFE, 0xFF
        endcase
        if (req.avail < nbytes)
            return REPL_CHAR;
        for (k = 1; k < nbytes; k++) begin
            if (req.bytes[k][7:6] != 2'b10)
                return REPL_CHAR;
            acc = (acc << 6) | 31'(req.bytes[k][5:0]);
        end
        if (acc < form_floor(nbytes) || (acc >= SURR_LO && acc <= SURR_HI) ||
            acc == NONCHAR_FE || acc == NONCHAR_FF)
            return REPL_CHAR;
        return acc;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Encode cp in an nbytes form; bytes past the form get random junk
    function automatic t_utf8_request encode_form(input logic [CP_W-1:0] cp,
                                                  input int unsigned nbytes,
                                                  input logic [LEN_W-1:0] avail);
        t_utf8_request     req;
        logic [BYTE_W-1:0] prefix;
        int unsigned       k;
        for (k = 0; k < 6; k++)
            req.bytes[k] = 8'($urandom);
        if (nbytes == 1) begin
            req.bytes[0] = {1'b0, cp[6:0]};
        end else begin
            prefix       = ~(8'hFF >> nbytes);
            req.bytes[0] = prefix | (8'(cp >> (6 * (nbytes - 1))) & (8'hFF >> (nbytes + 1)));
        end
        for (k = 1; k < nbytes; k++)
            req.bytes[k] = {2'b10, 6'(cp >> (6 * (nbytes - 1 - k)))};
        req.avail = avail;
        return req;
    endfunction

    // Enough bytes for the form; now and then the 7 that the port allows
    function automatic logic [LEN_W-1:0] roomy_avail(input int unsigned nbytes);
        if ($urandom_range(9) == 0)
            return 3'd7;
        return 3'($urandom_range(6, nbytes));
    endfunction

    function automatic t_utf8_request random_request();
        t_utf8_request req;
        int unsigned   roll;
        int unsigned   nbytes;
        int unsigned   k;
        logic [CP_W-1:0] cp;
        logic [1:0]    bad_tag;
        roll   = $urandom_range(99);
        nbytes = $urandom_range(6, 1);
        cp     = 31'($urandom_range(form_ceiling(nbytes), form_floor(nbytes)));
        if (roll < 60) begin
            // well-formed sequence, random payload
            req = encode_form(cp, nbytes, roomy_avail(nbytes));
        end else if (roll < 70) begin
            // well-formed framing around boundary and disallowed values
            case ($urandom_range(9))
                0: cp = form_floor(nbytes);
                1: cp = form_ceiling(nbytes);
                2: begin cp = 31'($urandom_range(SURR_HI, SURR_LO)); nbytes = 3; end
                3: begin cp = NONCHAR_FE;  nbytes = 3; end
                4: begin cp = NONCHAR_FF;  nbytes = 3; end
                5: begin cp = 31'(SURR_LO - 1); nbytes = 3; end
                6: begin cp = 31'(SURR_HI + 1); nbytes = 3; end
                7: begin cp = REPL_CHAR;   nbytes = 3; end
                default: cp = 31'(form_floor(nbytes) + 31'($urandom_range(63)));
            endcase
            req = encode_form(cp, nbytes, roomy_avail(nbytes));
        end else if (roll < 80) begin
            // overlong: value that fits a shorter form
            nbytes = $urandom_range(6, 2);
            if ($urandom_range(1) == 0)
                cp = 31'(form_floor(nbytes) - 1);
            else
                cp = 31'($urandom_range(form_floor(nbytes) - 1, 0));
            req = encode_form(cp, nbytes, roomy_avail(nbytes));
        end else if (roll < 88) begin
            // one continuation byte breaks the 10xxxxxx pattern
            nbytes  = $urandom_range(6, 2);
            cp      = 31'($urandom_range(form_ceiling(nbytes), form_floor(nbytes)));
            req     = encode_form(cp, nbytes, roomy_avail(nbytes));
            k       = $urandom_range(nbytes - 1, 1);
            bad_tag = 2'($urandom_range(2));
            if (bad_tag == 2'b10)
                bad_tag = 2'b11;
            req.bytes[k][7:6] = bad_tag;
        end else if (roll < 94) begin
            // buffer ends before the form does
            nbytes = $urandom_range(6, 2);
            cp     = 31'($urandom_range(form_ceiling(nbytes), form_floor(nbytes)));
            req    = encode_form(cp, nbytes, 3'($urandom_range(nbytes - 1, 0)));
        end else begin
            // raw noise on every byte and length
            req.bytes = 48'({$urandom(), $urandom()});
            req.avail = 3'($urandom_range(7));
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one request, hold it until the handshake
    // ------------------------------------------------------------------
    task automatic send_request(input t_utf8_request req);
        t_owed_code_point owed;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_lead_byte   = req.bytes[0];
        i_cont_byte_1 = req.bytes[1];
        i_cont_byte_2 = req.bytes[2];
        i_cont_byte_3 = req.bytes[3];
        i_cont_byte_4 = req.bytes[4];
        i_cont_byte_5 = req.bytes[5];
        i_avail_len   = req.avail;
        do
            @(posedge i_clk);
        while (!o_ready);
        owed.req = req;
        owed.cp  = decode_utf8(req);
        owed_code_points.push_back(owed);
        sequences_sent++;
    endtask

    // Drop valid and wait until every owed code point has come back
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (owed_code_points.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when a test asks
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : receiver
        int unsigned hold_left;
        if (hold_off_request != 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_ready)
            input_stall_cycles++;
    end

    // ------------------------------------------------------------------
    // Checker: each result against the oldest owed code point
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_owed_code_point owed;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_code_points.size() == 0) begin
                mismatch_count++;
                $error("code_point: none expected, actual %h", o_code_point);
            end else begin
                owed = owed_code_points.pop_front();
                code_points_seen++;
                if (owed.cp == REPL_CHAR)
                    replacements_seen++;
                if (o_code_point !== owed.cp) begin
                    mismatch_count++;
                    $error("code_point: expected %h, actual %h (bytes %h, avail %0d)",
                           owed.cp, o_code_point, owed.req.bytes, owed.req.avail);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Form extremes, disallowed values, bad leads and the odd lengths
    task automatic test_boundary_forms();
        t_utf8_request req;
        send_request(encode_form(31'h0000_0000, 1, 3'd1));
        send_request(encode_form(31'h0000_007F, 1, 3'd1));
        send_request(encode_form(31'h0000_0080, 2, 3'd2));
        send_request(encode_form(31'h0000_07FF, 2, 3'd2));
        send_request(encode_form(31'h0000_0800, 3, 3'd3));
        send_request(encode_form(31'(SURR_LO - 1), 3, 3'd3));
        send_request(encode_form(SURR_LO,       3, 3'd3));
        send_request(encode_form(SURR_HI,       3, 3'd3));
        send_request(encode_form(REPL_CHAR,     3, 3'd3));
        send_request(encode_form(NONCHAR_FE,    3, 3'd3));
        send_request(encode_form(NONCHAR_FF,    3, 3'd3));
        send_request(encode_form(31'h0001_0000, 4, 3'd4));
        send_request(encode_form(31'h001F_FFFF, 4, 3'd4));
        send_request(encode_form(31'h0020_0000, 5, 3'd5));
        send_request(encode_form(31'h03FF_FFFF, 5, 3'd6));
        send_request(encode_form(31'h0400_0000, 6, 3'd6));
        // largest value, with the length port at seven
        send_request(encode_form(31'h7FFF_FFFF, 6, 3'd7));
        // lead bytes that start no form
        req = encode_form(31'h0, 1, 3'd6); req.bytes[0] = 8'h80; send_request(req);
        req = encode_form(31'h0, 1, 3'd6); req.bytes[0] = 8'hFE; send_request(req);
        req = encode_form(31'h0, 1, 3'd6); req.bytes[0] = 8'hFF; send_request(req);
        // overlong two- and three-byte forms
        send_request(encode_form(31'h0000_007F, 2, 3'd2));
        send_request(encode_form(31'h0000_0000, 3, 3'd3));
        // zero bytes available, then one short of the form
        send_request(encode_form(31'h0000_0041, 1, 3'd0));
        send_request(encode_form(31'h0000_20AC, 3, 3'd2));
        // second byte is not a continuation
        req = encode_form(31'h0000_0080, 2, 3'd2); req.bytes[1] = 8'hC0; send_request(req);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        repeat (count)
            send_request(random_request());
    endtask

    // Receiver holds off while the sender keeps pushing: the block must fill
    // and push back on its input without losing a request
    task automatic test_input_backpressure();
        send_request(random_request());
        hold_off_request = 80;
        repeat (30)
            send_request(random_request());
    endtask

    // Sender goes quiet until the block is empty, then resumes
    task automatic test_sender_pause();
        repeat (12)
            send_request(random_request());
        wait_until_drained();
        repeat (12)
            send_request(random_request());
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 72;
        test_boundary_forms();
        test_random_traffic(485);

        send_idle_pct = 72;
        recv_idle_pct = 21;
        test_random_traffic(485);
        test_sender_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_input_backpressure();
        test_random_traffic(485);

        wait_until_drained();
        repeat (8) @(posedge i_clk);
        if (owed_code_points.size() != 0) begin
            mismatch_count++;
            $error("code_point: %0d results never arrived", owed_code_points.size());
        end

        $display("Sent %0d sequences; checked %0d code points, %0d of them U+FFFD.",
                 sequences_sent, code_points_seen, replacements_seen);
        $display("Input was held back for %0d cycles; %0d mismatches.",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_classify.sv
rtl/core/utf8d_assemble.sv
rtl/core/utf8d_check.sv
rtl/core/utf8_sequence_decoder.sv
sim/testbench.sv
